// ===== sv/strict_priority_multi_queue_defines.svh =====
// assertion macros for the strict priority multi-queue
// expects clk and arst_n in the scope where a macro is used
`ifndef STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SPMQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spmq_pkg.sv =====
// shared constants and types for the strict priority multi-queue
// no dependencies
package spmq_pkg;

	localparam int FIFO_COUNT  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;

	// port field widths are fixed
	localparam int QNUM_W = 3;
	localparam int DIN_W  = 32;

	// stored word width, never wider than the port
	localparam int WORD_W = (DATA_WIDTH < DIN_W) ? DATA_WIDTH : DIN_W;
	localparam int QIDX_W = $clog2(FIFO_COUNT);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = QIDX_W + PTR_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [QNUM_W-1:0] qnum;
	} req_t;

	typedef struct packed {
		logic              dropped;
		logic              hit;
		logic [QIDX_W-1:0] served;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
	} dec_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + 1'b1;
		return r;
	endfunction

endpackage

// ===== sv/spmq_sched.sv =====
// queue bookkeeping: head, tail and fill count per fifo, tail drop and priority pick
// depends on spmq_pkg
module spmq_sched (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  spmq_pkg::req_t req,
	output spmq_pkg::dec_t dec
);

	logic [spmq_pkg::PTR_W-1:0] head_q [spmq_pkg::FIFO_COUNT];
	logic [spmq_pkg::PTR_W-1:0] tail_q [spmq_pkg::FIFO_COUNT];
	logic [spmq_pkg::CNT_W-1:0] cnt_q  [spmq_pkg::FIFO_COUNT];

	logic [spmq_pkg::QIDX_W-1:0] enq_idx;
	logic                        in_range;
	logic                        enq_ok;
	logic                        any_busy;
	logic [spmq_pkg::QIDX_W-1:0] pick;

	assign in_range = int'(req.qnum) < spmq_pkg::FIFO_COUNT;
	assign enq_idx  = spmq_pkg::QIDX_W'(req.qnum);
	assign enq_ok   = (req.op == spmq_pkg::OP_ENQ) && in_range &&
		(cnt_q[enq_idx] != spmq_pkg::CNT_W'(spmq_pkg::QUEUE_DEPTH));

	// lowest non-empty fifo wins
	always_comb begin
		any_busy = 1'b0;
		pick     = '0;
		for (int i = spmq_pkg::FIFO_COUNT - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any_busy = 1'b1;
				pick     = spmq_pkg::QIDX_W'(i);
			end
		end
	end

	always_comb begin
		dec.dropped = (req.op == spmq_pkg::OP_ENQ) && !enq_ok;
		dec.hit     = (req.op == spmq_pkg::OP_DEQ) && any_busy;
		dec.served  = dec.hit ? pick : '0;
		dec.wr_en   = adv && enq_ok;
		dec.wr_addr = {enq_idx, tail_q[enq_idx]};
		dec.rd_addr = {pick, head_q[pick]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spmq_pkg::FIFO_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (adv) begin
			if (enq_ok) begin
				tail_q[enq_idx] <= spmq_pkg::ptr_next(tail_q[enq_idx]);
				cnt_q[enq_idx]  <= cnt_q[enq_idx] + 1'b1;
			end else if (dec.hit) begin
				head_q[pick] <= spmq_pkg::ptr_next(head_q[pick]);
				cnt_q[pick]  <= cnt_q[pick] - 1'b1;
			end
		end
	end

endmodule

// ===== sv/strict_priority_multi_queue.sv =====
// strict priority multi-queue: a bank of fifos in one shared word store, lowest number first
// depends on spmq_pkg, spmq_sched and strict_priority_multi_queue_defines.svh
//
// usage
//   input words carry op, queue_num and data_in on in_valid/in_ready. an enqueue
//   appends data_in to fifo queue_num, or sets dropped when that fifo is full.
//   a dequeue pops the oldest word of the lowest-numbered non-empty fifo and
//   reports it with out_valid, data_out and served_queue; with all fifos empty
//   it answers out_valid = 0 and zeros.
//   every input word yields one result word on res_valid/res_ready.
// timing
//   the input register holds a word while the bookkeeping decodes it; the store is
//   read into the result register, so a result passes the input register and then
//   the result register before it can leave. one word per cycle is sustained while
//   res_ready stays high; the store does at most one write or one read per word.
// reset and stall
//   arst_n empties every fifo at once; store contents are not cleared.
//   when res_ready is low the result register holds, the input register
//   still takes one more word, and in_ready drops after that.
`include "strict_priority_multi_queue_defines.svh"

module strict_priority_multi_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [2:0]  queue_num,
	input  logic [31:0] data_in,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        dropped,
	output logic        out_valid,
	output logic [31:0] data_out,
	output logic [2:0]  served_queue
);

	logic                         valid_s1;
	spmq_pkg::req_t               req_s1;
	logic [spmq_pkg::WORD_W-1:0]  word_s1;

	logic                         valid_s2;
	logic                         dropped_s2;
	logic                         hit_s2;
	logic [spmq_pkg::QIDX_W-1:0]  served_s2;
	logic [spmq_pkg::WORD_W-1:0]  rdata_s2;

	logic                         adv;
	spmq_pkg::dec_t               dec;

	logic [spmq_pkg::WORD_W-1:0]  mem [spmq_pkg::MEM_DEPTH];

	assign adv      = valid_s1 && (!valid_s2 || res_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (res_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.op   <= spmq_pkg::op_t'(op);
			req_s1.qnum <= queue_num;
			word_s1     <= data_in[spmq_pkg::WORD_W-1:0];
		end
		if (adv) begin
			dropped_s2 <= dec.dropped;
			hit_s2     <= dec.hit;
			served_s2  <= dec.served;
		end
	end

	spmq_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req_s1),
		.dec    (dec)
	);

	// word store, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (dec.wr_en)
			mem[dec.wr_addr] <= word_s1;
		if (adv && dec.hit)
			rdata_s2 <= mem[dec.rd_addr];
	end

	assign res_valid    = valid_s2;
	assign dropped      = dropped_s2;
	assign out_valid    = hit_s2;
	assign data_out     = hit_s2 ? 32'(rdata_s2) : '0;
	assign served_queue = 3'(served_s2);

	`SPMQ_ASSERT_NOW(a_excl, res_valid, !(dropped && out_valid), "dropped and out_valid both set")
	`SPMQ_ASSERT_NOW(a_stall, !in_ready, valid_s1 && valid_s2 && !res_ready, "in_ready low without stall")
	`SPMQ_ASSERT_NEXT(a_deq_hit, adv && dec.hit, res_valid && out_valid, "dequeue hit lost")
	`SPMQ_ASSERT_NEXT(a_enq_res, adv && (req_s1.op == spmq_pkg::OP_ENQ), res_valid && !out_valid, "enqueue gave a word")

endmodule

// ===== sim/tb.sv =====
// self-checking bench for strict_priority_multi_queue: directed then random enqueue/dequeue words
// predicts every result word with its own fifo bank; depends on spmq_pkg and the block's rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 780;
	localparam int STALL_PCT   = 32;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		logic        dropped;
		logic        out_valid;
		logic [31:0] data_out;
		logic [2:0]  served_queue;
	} sched_result_t;

	class sched_scoreboard;
		logic [spmq_pkg::WORD_W-1:0] store[spmq_pkg::FIFO_COUNT][spmq_pkg::QUEUE_DEPTH];
		logic [spmq_pkg::PTR_W-1:0]  head[spmq_pkg::FIFO_COUNT];
		logic [spmq_pkg::PTR_W-1:0]  tail[spmq_pkg::FIFO_COUNT];
		logic [spmq_pkg::CNT_W-1:0]  fill[spmq_pkg::FIFO_COUNT];
		sched_result_t               expected[$];
		int                          errors;

		function new();
			for (int q = 0; q < spmq_pkg::FIFO_COUNT; q++) begin
				head[q] = '0;
				tail[q] = '0;
				fill[q] = '0;
			end
			errors = 0;
		endfunction

		// indices wrap from the last slot back to zero
		function logic [spmq_pkg::PTR_W-1:0] bump(logic [spmq_pkg::PTR_W-1:0] p);
			if (p == spmq_pkg::PTR_W'(spmq_pkg::QUEUE_DEPTH - 1))
				return '0;
			return p + 1'b1;
		endfunction

		// work out the result of one accepted request word and queue it
		function void accept_request(spmq_pkg::op_t kind, logic [2:0] qn, logic [31:0] din);
			sched_result_t r;
			r = '{1'b0, 1'b0, 32'd0, 3'd0};
			if (kind == spmq_pkg::OP_ENQ) begin
				if (int'(qn) >= spmq_pkg::FIFO_COUNT ||
						fill[qn] == spmq_pkg::CNT_W'(spmq_pkg::QUEUE_DEPTH)) begin
					r.dropped = 1'b1;
				end else begin
					store[qn][tail[qn]] = din[spmq_pkg::WORD_W-1:0];
					tail[qn] = bump(tail[qn]);
					fill[qn]++;
				end
			end else begin
				for (int q = 0; q < spmq_pkg::FIFO_COUNT; q++) begin
					if (fill[q] != 0) begin
						r.out_valid    = 1'b1;
						r.data_out     = 32'(store[q][head[q]]);
						r.served_queue = 3'(q);
						head[q] = bump(head[q]);
						fill[q]--;
						break;
					end
				end
			end
			expected.push_back(r);
		endfunction

		function void check_result(logic dr, logic ov, logic [31:0] dout, logic [2:0] sq);
			sched_result_t e;
			if (expected.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = expected.pop_front();
			if (dr !== e.dropped) begin
				$error("dropped: expected %0h, got %0h", e.dropped, dr);
				errors++;
			end
			if (ov !== e.out_valid) begin
				$error("out_valid: expected %0h, got %0h", e.out_valid, ov);
				errors++;
			end
			if (dout !== e.data_out) begin
				$error("data_out: expected %08h, got %08h", e.data_out, dout);
				errors++;
			end
			if (sq !== e.served_queue) begin
				$error("served_queue: expected %0d, got %0d", e.served_queue, sq);
				errors++;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [2:0]  queue_num = 3'd0;
	logic [31:0] data_in = 32'd0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        dropped;
	logic        out_valid;
	logic [31:0] data_out;
	logic [2:0]  served_queue;

	bit  calm = 1'b0;
	int  quiet_cycles = 0;
	sched_scoreboard sb = new();

	strict_priority_multi_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.queue_num    (queue_num),
		.data_in      (data_in),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.dropped      (dropped),
		.out_valid    (out_valid),
		.data_out     (data_out),
		.served_queue (served_queue)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_ready <= calm || ($urandom_range(99) >= STALL_PCT);
	end

	// requests are noted before results so a same-edge pair stays in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.accept_request(spmq_pkg::op_t'(op), queue_num, data_in);
			if (res_valid && res_ready)
				sb.check_result(dropped, out_valid, data_out, served_queue);
			if ((in_valid && in_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(spmq_pkg::op_t kind, logic [2:0] qn, logic [31:0] din);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= kind;
		queue_num <= qn;
		data_in   <= din;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic run_directed();
		send_word(spmq_pkg::OP_DEQ, 3'd0, 32'hFFFF_FFFF);   // every fifo empty
		send_word(spmq_pkg::OP_ENQ, 3'd7, 32'h0000_0000);
		send_word(spmq_pkg::OP_ENQ, 3'd0, 32'hFFFF_FFFF);
		send_word(spmq_pkg::OP_DEQ, 3'd5, 32'h0);           // queue 0 wins over 7
		send_word(spmq_pkg::OP_DEQ, 3'd0, 32'h0);
		send_word(spmq_pkg::OP_DEQ, 3'd0, 32'h0);
		// fill queue 2 and push one more to see the tail drop
		for (int k = 0; k <= spmq_pkg::QUEUE_DEPTH; k++)
			send_word(spmq_pkg::OP_ENQ, 3'd2, 32'hA5A5_0000 | 32'(k));
		send_word(spmq_pkg::OP_ENQ, 3'd1, 32'h8000_0001);
		send_word(spmq_pkg::OP_DEQ, 3'd0, 32'h0);
	endtask

	task automatic run_random();
		spmq_pkg::op_t kind;
		logic [2:0]    qn;
		logic [31:0]   din;
		int            enq_pct;
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 350 && i < 470);
			// alternate filling and draining phases so fifos hit full, wrap and run dry
			enq_pct = ((i / 100) % 2 == 0) ? 75 : 30;
			kind = ($urandom_range(99) < enq_pct) ? spmq_pkg::OP_ENQ : spmq_pkg::OP_DEQ;
			if ($urandom_range(3) == 0)
				qn = 3'($urandom_range(1));
			else
				qn = 3'($urandom_range(7));
			case ($urandom_range(9))
				0: din = 32'h0;
				1: din = 32'hFFFF_FFFF;
				default: din = $urandom;
			endcase
			send_word(kind, qn, din);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/spmq_pkg.sv
sv/spmq_sched.sv
sv/strict_priority_multi_queue.sv
sim/tb.sv
